// File: src/sobel_gradient_3x3_unit_assert.svh
// Assertion macros for the Sobel gradient unit.
// Expects signals named clock and reset in the scope where a macro is used.
`ifndef SOBEL_GRADIENT_3X3_UNIT_ASSERT_SVH
`define SOBEL_GRADIENT_3X3_UNIT_ASSERT_SVH

`ifndef SYNTH

`define SG3_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("sg3 assertion failed");

`define SG3_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sg3 assertion failed");

`define SG3_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sg3 assertion failed");

`else

`define SG3_ASSERT(label, prop)

`define SG3_ASSERT_IMPLIES(label, ante, cons)

`define SG3_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: src/sg3_pkg.sv
// Shared types and constants of the Sobel gradient unit.
// No dependencies; the other files that use it refer to this package by scoped names.
package sg3_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CFG_WIDTH_W = 11;
   localparam int WEFF_W = ($clog2(MAX_WIDTH + 1) > CFG_WIDTH_W) ?
                           $clog2(MAX_WIDTH + 1) : CFG_WIDTH_W;
   localparam int HEIGHT_W = 12;
   localparam int ROW_W = HEIGHT_W + 1;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_INDEX_W = 1;
   localparam int PIX_W = 8;
   localparam int GRAD_W = 11;
   localparam int MAG_W = 8;
   localparam int MAG_MAX = 255;
   localparam int WIDTH_RESET = 640;
   localparam int HEIGHT_RESET = 480;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

   // Window indexed [row][column]; row 0 is the top row, column 2 the newest.
   typedef logic [2:0][2:0][PIX_W-1:0] win_type;

   // Where the centre pixel of one request lies and which neighbors are inside.
   typedef struct packed {
      logic             have;
      logic             last;
      logic             top_ok;
      logic             bot_ok;
      logic             left_ok;
      logic             right_ok;
      logic [COL_W-1:0] col;
   } pos_type;

endpackage

// File: src/sg3_req_if.sv
// Request channel of the Sobel gradient unit: one pixel or flush per request.
// Depends on sg3_pkg for field widths.
interface sg3_req_if;
   logic                      valid;
   logic                      ready;
   logic [sg3_pkg::PIX_W-1:0] pixel_value;
   logic                      flush;

   modport source (output valid, output pixel_value, output flush, input ready);
   modport sink (input valid, input pixel_value, input flush, output ready);
endinterface

// File: src/sg3_rsp_if.sv
// Result channel of the Sobel gradient unit: gradients and magnitude.
// Depends on sg3_pkg for field widths.
interface sg3_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [sg3_pkg::GRAD_W-1:0] grad_x;
   logic signed [sg3_pkg::GRAD_W-1:0] grad_y;
   logic [sg3_pkg::MAG_W-1:0]         magnitude;
   logic                              last_of_frame;

   modport source (output valid, output grad_x, output grad_y, output magnitude,
                   output last_of_frame, input ready);
   modport sink (input valid, input grad_x, input grad_y, input magnitude,
                 input last_of_frame, output ready);
endinterface

// File: src/sg3_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the two line buffers.
module sg3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/sg3_locate.sv
// Column and row counters of the Sobel gradient unit, and the position of the
// centre pixel that each request completes. Depends on sg3_pkg.
module sg3_locate (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  logic                          advance,
   input  logic [sg3_pkg::WEFF_W-1:0]    width,
   input  logic [sg3_pkg::HEIGHT_W-1:0]  height,
   output sg3_pkg::pos_type              pos
);

   logic [sg3_pkg::COL_W-1:0]  col_ff, col_in;
   logic [sg3_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [sg3_pkg::WEFF_W-1:0] col_w;
   logic [sg3_pkg::WEFF_W-1:0] col_next;
   logic [sg3_pkg::WEFF_W-1:0] cc;
   logic [sg3_pkg::ROW_W-1:0]  rc;
   logic [sg3_pkg::ROW_W-1:0]  height_r;
   logic                       centre;

   assign col_w = sg3_pkg::WEFF_W'(col_ff);
   assign col_next = col_w + sg3_pkg::WEFF_W'(1);
   assign height_r = sg3_pkg::ROW_W'(height);

   // The centre lags one row plus one pixel; at column zero it is the last
   // pixel of the row two rows up.
   always_comb begin
      if (col_ff != '0) begin
         cc = col_w - sg3_pkg::WEFF_W'(1);
         centre = (row_ff != '0);
         rc = row_ff - sg3_pkg::ROW_W'(1);
      end else begin
         cc = width - sg3_pkg::WEFF_W'(1);
         centre = (row_ff >= sg3_pkg::ROW_W'(2));
         rc = row_ff - sg3_pkg::ROW_W'(2);
      end
      pos.have = centre && (rc < height_r);
      pos.last = pos.have && (rc == height_r - sg3_pkg::ROW_W'(1)) &&
                 (cc == width - sg3_pkg::WEFF_W'(1));
      pos.top_ok = (rc != '0);
      pos.bot_ok = (rc + sg3_pkg::ROW_W'(1)) < height_r;
      pos.left_ok = (cc != '0);
      pos.right_ok = (cc + sg3_pkg::WEFF_W'(1)) < width;
      pos.col = col_ff;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (advance) begin
         if (pos.last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_next >= width) begin
            col_in = '0;
            row_in = row_ff + sg3_pkg::ROW_W'(1);
         end else begin
            col_in = col_next[sg3_pkg::COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// File: src/sg3_kernel.sv
// Sobel 3x3 kernel: masks neighbors outside the frame, forms both gradients
// and the saturated magnitude. Depends on sg3_pkg.
module sg3_kernel (
   input  sg3_pkg::win_type                  win,
   input  sg3_pkg::pos_type                  pos,
   output logic signed [sg3_pkg::GRAD_W-1:0] grad_x,
   output logic signed [sg3_pkg::GRAD_W-1:0] grad_y,
   output logic [sg3_pkg::MAG_W-1:0]         magnitude
);

   logic signed [sg3_pkg::GRAD_W-1:0] v [3][3];
   logic [sg3_pkg::GRAD_W-1:0]        abs_x;
   logic [sg3_pkg::GRAD_W-1:0]        abs_y;
   logic [sg3_pkg::GRAD_W:0]          abs_sum;
   logic [sg3_pkg::GRAD_W-1:0]        half;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            logic ok;
            ok = 1'b1;
            if (r == 0 && !pos.top_ok) ok = 1'b0;
            if (r == 2 && !pos.bot_ok) ok = 1'b0;
            if (c == 0 && !pos.left_ok) ok = 1'b0;
            if (c == 2 && !pos.right_ok) ok = 1'b0;
            v[r][c] = ok ? sg3_pkg::GRAD_W'(win[r][c]) : '0;
         end
      end
   end

   assign grad_x = (v[0][2] - v[0][0]) + ((v[1][2] - v[1][0]) <<< 1) + (v[2][2] - v[2][0]);
   assign grad_y = (v[2][0] - v[0][0]) + ((v[2][1] - v[0][1]) <<< 1) + (v[2][2] - v[0][2]);

   assign abs_x = grad_x[sg3_pkg::GRAD_W-1] ? -grad_x : grad_x;
   assign abs_y = grad_y[sg3_pkg::GRAD_W-1] ? -grad_y : grad_y;
   assign abs_sum = {1'b0, abs_x} + {1'b0, abs_y};
   assign half = abs_sum[sg3_pkg::GRAD_W:1];
   assign magnitude = (half > sg3_pkg::GRAD_W'(sg3_pkg::MAG_MAX)) ?
                      sg3_pkg::MAG_W'(sg3_pkg::MAG_MAX) : half[sg3_pkg::MAG_W-1:0];

endmodule

// File: src/sobel_gradient_3x3_unit.sv
// Top level of the streaming 3x3 Sobel gradient unit.
// Uses sg3_pkg, sg3_req_if, sg3_rsp_if, sg3_ram, sg3_locate and sg3_kernel.
//
// Pixels enter in raster order on req_if, one request per clock at most;
// results leave on rsp_if with both gradients, the magnitude (|gx|+|gy|)/2
// saturated to 255, and a flag on the frame's final pixel. The result for a
// pixel comes with the request image_width + 1 positions later, so a frame is
// followed by image_width + 1 flush requests.
// The block takes one request every cycle while req_if.ready is high. A request
// waits in a stage register while both line buffer RAMs are read; its result
// then enters the output register, which drives rsp_if.valid, once that
// register is empty or being emptied. When rsp_if.ready
// is low the output register holds, and req_if.ready falls in that same cycle
// once the stage register is full as well.
// Configuration writes on the csr_ port take effect at once and restart the
// frame; write them only while no request is in flight. Reset sets a 640 x 480
// frame and clears counters and window; the line buffers are not cleared
// because entries outside the frame are masked.
`include "sobel_gradient_3x3_unit_assert.svh"

module sobel_gradient_3x3_unit (
   input  logic                             clock,
   input  logic                             reset,
   sg3_req_if.sink                          req_if,
   sg3_rsp_if.source                        rsp_if,
   input  logic                             csr_wr_en,
   input  logic [sg3_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sg3_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   logic [sg3_pkg::WEFF_W-1:0]   width_ff, width_in;
   logic [sg3_pkg::HEIGHT_W-1:0] height_ff, height_in;
   logic [sg3_pkg::WEFF_W-1:0]   width_raw;

   sg3_pkg::pos_type             loc_pos;
   logic                         accept;
   logic                         advance;
   logic                         s1_fire;

   logic                         s1_valid_ff, s1_valid_in;
   logic [sg3_pkg::PIX_W-1:0]    s1_pix_ff;
   sg3_pkg::pos_type             s1_pos_ff;
   logic                         byp_ff, byp_in;
   logic [sg3_pkg::PIX_W-1:0]    byp_up_ff;
   logic [sg3_pkg::PIX_W-1:0]    byp_mid_ff;

   logic [sg3_pkg::PIX_W-1:0]    up_rd;
   logic [sg3_pkg::PIX_W-1:0]    mid_rd;
   logic [sg3_pkg::PIX_W-1:0]    up_new;
   logic [sg3_pkg::PIX_W-1:0]    mid_new;

   sg3_pkg::win_type             win_ff, win_in, win_shift;

   logic signed [sg3_pkg::GRAD_W-1:0] gx;
   logic signed [sg3_pkg::GRAD_W-1:0] gy;
   logic [sg3_pkg::MAG_W-1:0]         mag;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [sg3_pkg::GRAD_W-1:0] rsp_gx_ff;
   logic signed [sg3_pkg::GRAD_W-1:0] rsp_gy_ff;
   logic [sg3_pkg::MAG_W-1:0]         rsp_mag_ff;
   logic                              rsp_last_ff;

   // Configuration: store the effective width and height.
   assign width_raw = sg3_pkg::WEFF_W'(csr_wr_data[sg3_pkg::CFG_WIDTH_W-1:0]);

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            sg3_pkg::REG_IMAGE_WIDTH: begin
               if (width_raw == '0) begin
                  width_in = sg3_pkg::WEFF_W'(1);
               end else if (width_raw > sg3_pkg::WEFF_W'(sg3_pkg::MAX_WIDTH)) begin
                  width_in = sg3_pkg::WEFF_W'(sg3_pkg::MAX_WIDTH);
               end else begin
                  width_in = width_raw;
               end
            end
            sg3_pkg::REG_IMAGE_HEIGHT: begin
               if (csr_wr_data[sg3_pkg::HEIGHT_W-1:0] == '0) begin
                  height_in = sg3_pkg::HEIGHT_W'(1);
               end else begin
                  height_in = csr_wr_data[sg3_pkg::HEIGHT_W-1:0];
               end
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   // Handshake: the output register frees the stage register, which frees
   // the request side.
   assign advance = !rsp_valid_ff || rsp_if.ready;
   assign s1_fire = s1_valid_ff && advance;
   assign req_if.ready = !s1_valid_ff || advance;
   assign accept = req_if.valid && req_if.ready;

   sg3_locate u_locate (
      .clock   (clock),
      .reset   (reset),
      .restart (csr_wr_en),
      .advance (accept),
      .width   (width_ff),
      .height  (height_ff),
      .pos     (loc_pos)
   );

   // A request reading the column that the departing request writes in the
   // same cycle takes the written values from the bypass registers.
   assign up_new = byp_ff ? byp_up_ff : up_rd;
   assign mid_new = byp_ff ? byp_mid_ff : mid_rd;

   sg3_ram #(
      .WIDTH (sg3_pkg::PIX_W),
      .DEPTH (sg3_pkg::MAX_WIDTH)
   ) u_line_upper (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_pos_ff.col),
      .wr_data (mid_new),
      .rd_en   (accept),
      .rd_addr (loc_pos.col),
      .rd_data (up_rd)
   );

   sg3_ram #(
      .WIDTH (sg3_pkg::PIX_W),
      .DEPTH (sg3_pkg::MAX_WIDTH)
   ) u_line_middle (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_pos_ff.col),
      .wr_data (s1_pix_ff),
      .rd_en   (accept),
      .rd_addr (loc_pos.col),
      .rd_data (mid_rd)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      byp_in = byp_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         byp_in = s1_fire && (loc_pos.col == s1_pos_ff.col);
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
         byp_in = 1'b0;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_shift[r][0] = win_ff[r][1];
         win_shift[r][1] = win_ff[r][2];
      end
      win_shift[0][2] = up_new;
      win_shift[1][2] = mid_new;
      win_shift[2][2] = s1_pix_ff;
   end

   always_comb begin
      win_in = win_ff;
      if (csr_wr_en) begin
         win_in = '0;
      end else if (s1_fire) begin
         win_in = s1_pos_ff.last ? '0 : win_shift;
      end
   end

   sg3_kernel u_kernel (
      .win       (win_shift),
      .pos       (s1_pos_ff),
      .grad_x    (gx),
      .grad_y    (gy),
      .magnitude (mag)
   );

   assign rsp_valid_in = advance ? (s1_valid_ff && s1_pos_ff.have) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= sg3_pkg::WEFF_W'(sg3_pkg::WIDTH_RESET);
         height_ff <= sg3_pkg::HEIGHT_W'(sg3_pkg::HEIGHT_RESET);
         s1_valid_ff <= 1'b0;
         byp_ff <= 1'b0;
         win_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
         s1_valid_ff <= s1_valid_in;
         byp_ff <= byp_in;
         win_ff <= win_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff <= req_if.flush ? '0 : req_if.pixel_value;
         s1_pos_ff <= loc_pos;
         byp_up_ff <= mid_new;
         byp_mid_ff <= s1_pix_ff;
      end
      if (s1_fire && s1_pos_ff.have) begin
         rsp_gx_ff <= gx;
         rsp_gy_ff <= gy;
         rsp_mag_ff <= mag;
         rsp_last_ff <= s1_pos_ff.last;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.grad_x = rsp_gx_ff;
   assign rsp_if.grad_y = rsp_gy_ff;
   assign rsp_if.magnitude = rsp_mag_ff;
   assign rsp_if.last_of_frame = rsp_last_ff;

   `SG3_ASSERT(a_col_in_frame, sg3_pkg::WEFF_W'(loc_pos.col) < width_ff)
   `SG3_ASSERT_NEXT(a_restart_clears, csr_wr_en, loc_pos.col == '0 && !loc_pos.have)
   `SG3_ASSERT_IMPLIES(a_bypass_needs_stage, byp_ff, s1_valid_ff)
   `SG3_ASSERT_IMPLIES(a_rsp_from_stage, $rose(rsp_valid_ff), $past(s1_valid_ff))

endmodule
